// ----- rtl/gfc7_pkg.sv -----
// Shared constants, types and the seven-segment decoder of the gated frequency counter.
`default_nettype none

package gfc7_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned GATE_BITS_DEF   = 24;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_THRESHOLD    = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_GATE_SAMPLES = cfg_idx_t'(1);

  // Reset values: the threshold sits at 33 percent of full scale, rounded.
  localparam int unsigned THRESH_PCT  = 33;
  localparam int unsigned PCT_SCALE   = 100;
  localparam int unsigned GATE_RESET  = 1000000;

  // Result fields
  localparam int unsigned FREQ_BITS  = 10;
  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned SEG_BITS   = 7;
  localparam logic [FREQ_BITS-1:0] FREQ_MAX = FREQ_BITS'(999);

  // Decimal split by reciprocal multiplication, exact for the ranges used here.
  localparam int unsigned DIV100_MUL   = 41;
  localparam int unsigned DIV100_SHIFT = 12;
  localparam int unsigned DIV10_MUL    = 205;
  localparam int unsigned DIV10_SHIFT  = 11;
  localparam int unsigned HUNDRED      = 100;
  localparam int unsigned TEN          = 10;

  typedef struct packed {
    logic [FREQ_BITS-1:0] freq;
    logic                 over;
  } meas_t;

  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [SEG_BITS-1:0]   seg_t;

  // Segment a is bit 0, segment g is bit 6.
  function automatic seg_t seg7(input digit_t d);
    seg_t s;
    unique case (d)
      digit_t'(0): s = seg_t'(7'h3F);
      digit_t'(1): s = seg_t'(7'h06);
      digit_t'(2): s = seg_t'(7'h5B);
      digit_t'(3): s = seg_t'(7'h4F);
      digit_t'(4): s = seg_t'(7'h66);
      digit_t'(5): s = seg_t'(7'h6D);
      digit_t'(6): s = seg_t'(7'h7D);
      digit_t'(7): s = seg_t'(7'h07);
      digit_t'(8): s = seg_t'(7'h7F);
      digit_t'(9): s = seg_t'(7'h6F);
      default:     s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gfc7_ifs.sv -----
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none

interface gfc7_sample_if #(
  parameter int unsigned SAMPLE_BITS = gfc7_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gfc7_result_if;
  logic                                valid;
  logic                                ready;
  logic [gfc7_pkg::FREQ_BITS-1:0]      frequency;
  logic                                overrange;
  logic [gfc7_pkg::DIGIT_BITS-1:0]     digit_hundreds;
  logic [gfc7_pkg::DIGIT_BITS-1:0]     digit_tens;
  logic [gfc7_pkg::DIGIT_BITS-1:0]     digit_ones;
  logic [gfc7_pkg::SEG_BITS-1:0]       seg_hundreds;
  logic [gfc7_pkg::SEG_BITS-1:0]       seg_tens;
  logic [gfc7_pkg::SEG_BITS-1:0]       seg_ones;

  modport source (output valid, output frequency, output overrange, output digit_hundreds,
                  output digit_tens, output digit_ones, output seg_hundreds,
                  output seg_tens, output seg_ones, input ready);
  modport sink   (input valid, input frequency, input overrange, input digit_hundreds,
                  input digit_tens, input digit_ones, input seg_hundreds,
                  input seg_tens, input seg_ones, output ready);
endinterface

interface gfc7_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [gfc7_pkg::CFG_IDX_BITS-1:0]    index;
  logic [gfc7_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/gated_frequency_counter_7seg.sv -----
// Gated frequency counter top level: configuration registers and the two processing stages.
//
// Usage: converter samples arrive on sample_i, one per transfer. Each sample is compared
// with the threshold; a change of side counts one crossing. After gate_samples samples the
// block sends one result on result_o: half the crossing count saturated at 999, the
// overrange flag, three decimal digits and their seven-segment codes. Counters then clear;
// the level flag carries over into the next gate. Samples that do not close a gate give no
// result.
// Configuration: cfg_i writes threshold (index 0) or gate_samples (index 1); other indexes
// are ignored. The port is always ready. The user must make writes only while no gate result
// is pending; the block itself does not enforce this. Throughput: one sample per cycle unless
// a stall (below) holds the sample that closes a gate. A result passes through the input
// register, then the measurement register, then the display output register.
// Reset: threshold 1352, gate_samples 1000000, counters zero, level flag low, no result.
// Stall: the output register holds its result while result_o.ready is low and one more
// result waits in the measurement register; samples keep flowing until one that closes a
// gate finds both full, and only then does sample_i.ready drop.
`default_nettype none

module gated_frequency_counter_7seg #(
  parameter int unsigned SAMPLE_BITS = gfc7_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GATE_BITS   = gfc7_pkg::GATE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gfc7_sample_if.sink   sample_i,
  gfc7_result_if.source result_o,
  gfc7_cfg_if.sink      cfg_i
);

  localparam logic [SAMPLE_BITS-1:0] THRESH_RST = SAMPLE_BITS'(
      ((2 ** SAMPLE_BITS) * gfc7_pkg::THRESH_PCT + gfc7_pkg::PCT_SCALE / 2) /
      gfc7_pkg::PCT_SCALE);
  localparam logic [GATE_BITS-1:0] GATE_RST = GATE_BITS'(gfc7_pkg::GATE_RESET);

  logic [SAMPLE_BITS-1:0] threshold_q, threshold_d;
  logic [GATE_BITS-1:0]   gate_q, gate_d;

  logic                   meas_valid;
  logic                   meas_ready;
  gfc7_pkg::meas_t        meas;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    threshold_d = threshold_q;
    gate_d      = gate_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        gfc7_pkg::CFG_THRESHOLD:    threshold_d = cfg_i.data[SAMPLE_BITS-1:0];
        gfc7_pkg::CFG_GATE_SAMPLES: gate_d      = cfg_i.data[GATE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESH_RST;
      gate_q      <= GATE_RST;
    end else begin
      threshold_q <= threshold_d;
      gate_q      <= gate_d;
    end
  end

  gfc7_gate #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .GATE_BITS   (GATE_BITS)
  ) u_gate (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .threshold_i    (threshold_q),
    .gate_samples_i (gate_q),
    .meas_valid_o   (meas_valid),
    .meas_ready_i   (meas_ready),
    .meas_o         (meas)
  );

  gfc7_disp u_disp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .meas_valid_i (meas_valid),
    .meas_ready_o (meas_ready),
    .meas_i       (meas),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

// ----- rtl/gfc7_gate.sv -----
// Input register, crossing detector, gate counters and saturated frequency register.
`default_nettype none

module gfc7_gate #(
  parameter int unsigned SAMPLE_BITS = gfc7_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GATE_BITS   = gfc7_pkg::GATE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  gfc7_sample_if.sink            sample_i,
  input  logic [SAMPLE_BITS-1:0] threshold_i,
  input  logic [GATE_BITS-1:0]   gate_samples_i,
  output logic                   meas_valid_o,
  input  logic                   meas_ready_i,
  output gfc7_pkg::meas_t        meas_o
);

  localparam int unsigned HALF_W =
      (GATE_BITS > gfc7_pkg::FREQ_BITS) ? GATE_BITS : gfc7_pkg::FREQ_BITS;

  logic                   in_valid_q, in_valid_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   level_q, level_d;
  logic [GATE_BITS:0]     cross_q, cross_d;
  logic [GATE_BITS-1:0]   cnt_q, cnt_d;
  logic                   meas_valid_q, meas_valid_d;
  gfc7_pkg::meas_t        meas_q;

  logic                   accept;
  logic                   cross_hit;
  logic [GATE_BITS:0]     cross_inc;
  logic [GATE_BITS-1:0]   cnt_inc;
  logic                   gate_end;
  logic [HALF_W-1:0]      half_ext;
  gfc7_pkg::meas_t        meas_new;
  logic                   meas_free;
  logic                   step;

  // A crossing is counted when the wave reaches the threshold from the side the flag marks.
  assign cross_hit = (!level_q && (sample_q >= threshold_i)) ||
                     (level_q && (sample_q <= threshold_i));
  assign cross_inc = cross_q + (GATE_BITS + 1)'(cross_hit);
  assign cnt_inc   = cnt_q + GATE_BITS'(1);
  // A zero gate length makes every sample close a gate, which this compare covers.
  assign gate_end  = (cnt_inc == '0) || (cnt_inc >= gate_samples_i);

  assign half_ext      = HALF_W'(cross_inc[GATE_BITS:1]);
  assign meas_new.over = half_ext > HALF_W'(gfc7_pkg::FREQ_MAX);
  assign meas_new.freq = meas_new.over ? gfc7_pkg::FREQ_MAX
                                       : half_ext[gfc7_pkg::FREQ_BITS-1:0];

  // Only a sample that closes a gate has to wait for room in the measurement register.
  assign meas_free      = !meas_valid_q || meas_ready_i;
  assign step           = in_valid_q && (!gate_end || meas_free);
  assign sample_i.ready = !in_valid_q || step;
  assign accept         = sample_i.valid && sample_i.ready;

  always_comb begin
    in_valid_d   = accept || (in_valid_q && !step);
    level_d      = level_q;
    cross_d      = cross_q;
    cnt_d        = cnt_q;
    meas_valid_d = meas_valid_q && !meas_ready_i;
    if (step) begin
      level_d = level_q ^ cross_hit;
      if (gate_end) begin
        cross_d      = '0;
        cnt_d        = '0;
        meas_valid_d = 1'b1;
      end else begin
        cross_d = cross_inc;
        cnt_d   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      level_q      <= 1'b0;
      cross_q      <= '0;
      cnt_q        <= '0;
      meas_valid_q <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      level_q      <= level_d;
      cross_q      <= cross_d;
      cnt_q        <= cnt_d;
      meas_valid_q <= meas_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i.sample;
    end
    if (step && gate_end) begin
      meas_q <= meas_new;
    end
  end

  assign meas_valid_o = meas_valid_q;
  assign meas_o       = meas_q;

  a_gate_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && gate_end |=> (cnt_q == '0) && (cross_q == '0))
    else $error("counters not cleared after a gate closed");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(cnt_q) && $stable(cross_q) && $stable(level_q))
    else $error("gate state moved without a processed sample");

  a_level_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !gate_end |=> ((level_q != $past(level_q)) == (cross_q != $past(cross_q))))
    else $error("level flag and crossing count disagree");

endmodule

`default_nettype wire

// ----- rtl/gfc7_disp.sv -----
// Decimal digit split, seven-segment decode and the output register.
`default_nettype none

module gfc7_disp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            meas_valid_i,
  output logic            meas_ready_o,
  input  gfc7_pkg::meas_t meas_i,
  gfc7_result_if.source   result_o
);

  localparam int unsigned HPROD_W = gfc7_pkg::DIGIT_BITS + gfc7_pkg::DIV100_SHIFT;
  localparam int unsigned REM_W   = 7;
  localparam int unsigned TPROD_W = gfc7_pkg::DIGIT_BITS + gfc7_pkg::DIV10_SHIFT;

  logic                              out_valid_q, out_valid_d;
  logic [gfc7_pkg::FREQ_BITS-1:0]    freq_q;
  logic                              over_q;
  gfc7_pkg::digit_t                  dig_h_q, dig_t_q, dig_o_q;
  gfc7_pkg::seg_t                    seg_h_q, seg_t_q, seg_o_q;

  logic                              load;
  logic [HPROD_W-1:0]                h_prod;
  gfc7_pkg::digit_t                  dig_h;
  logic [REM_W-1:0]                  rem;
  logic [TPROD_W-1:0]                t_prod;
  gfc7_pkg::digit_t                  dig_t;
  gfc7_pkg::digit_t                  dig_o;

  assign meas_ready_o = !out_valid_q || result_o.ready;
  assign load         = meas_valid_i && meas_ready_o;

  // freq / 100 and rem / 10 via multiply-and-shift; both are exact below 1000 and 160.
  assign h_prod = HPROD_W'(meas_i.freq) * HPROD_W'(gfc7_pkg::DIV100_MUL);
  assign dig_h  = h_prod[gfc7_pkg::DIV100_SHIFT +: gfc7_pkg::DIGIT_BITS];
  assign rem    = REM_W'(meas_i.freq - gfc7_pkg::FREQ_BITS'(dig_h) *
                         gfc7_pkg::FREQ_BITS'(gfc7_pkg::HUNDRED));
  assign t_prod = TPROD_W'(rem) * TPROD_W'(gfc7_pkg::DIV10_MUL);
  assign dig_t  = t_prod[gfc7_pkg::DIV10_SHIFT +: gfc7_pkg::DIGIT_BITS];
  assign dig_o  = gfc7_pkg::DIGIT_BITS'(rem - REM_W'(dig_t) * REM_W'(gfc7_pkg::TEN));

  assign out_valid_d = load || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      freq_q  <= meas_i.freq;
      over_q  <= meas_i.over;
      dig_h_q <= dig_h;
      dig_t_q <= dig_t;
      dig_o_q <= dig_o;
      seg_h_q <= gfc7_pkg::seg7(dig_h);
      seg_t_q <= gfc7_pkg::seg7(dig_t);
      seg_o_q <= gfc7_pkg::seg7(dig_o);
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.frequency      = freq_q;
  assign result_o.overrange      = over_q;
  assign result_o.digit_hundreds = dig_h_q;
  assign result_o.digit_tens     = dig_t_q;
  assign result_o.digit_ones     = dig_o_q;
  assign result_o.seg_hundreds   = seg_h_q;
  assign result_o.seg_tens       = seg_t_q;
  assign result_o.seg_ones       = seg_o_q;

  a_over_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && over_q |-> freq_q == gfc7_pkg::FREQ_MAX)
    else $error("overrange set without a saturated frequency");

  a_digits_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (gfc7_pkg::FREQ_BITS'(dig_h_q) * gfc7_pkg::FREQ_BITS'(gfc7_pkg::HUNDRED) +
                     gfc7_pkg::FREQ_BITS'(dig_t_q) * gfc7_pkg::FREQ_BITS'(gfc7_pkg::TEN) +
                     gfc7_pkg::FREQ_BITS'(dig_o_q)) == freq_q)
    else $error("decimal digits do not add up to the frequency");

  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (dig_h_q <= gfc7_pkg::digit_t'(9)) && (dig_t_q <= gfc7_pkg::digit_t'(9)) &&
                    (dig_o_q <= gfc7_pkg::digit_t'(9)))
    else $error("digit out of decimal range");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the gated frequency counter with seven-segment readout.
module tb;

  localparam int unsigned SAMPLE_BITS     = gfc7_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned GATE_BITS       = gfc7_pkg::GATE_BITS_DEF;
  localparam int unsigned SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned GATE_MAX        = (1 << GATE_BITS) - 1;
  localparam int unsigned RESET_THRESHOLD = 1352;
  localparam int unsigned MID_THRESHOLD   = 2048;
  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned PHASES          = 4;
  localparam int unsigned PHASE_SEGMENTS  = 5;
  localparam int unsigned SEGMENT_SAMPLES = 15;
  localparam int unsigned HOLD_CYCLES     = 300;

  localparam gfc7_pkg::cfg_idx_t CFG_SPARE_LO = gfc7_pkg::cfg_idx_t'(2);
  localparam gfc7_pkg::cfg_idx_t CFG_SPARE_HI = gfc7_pkg::cfg_idx_t'(3);

  // Segment a is bit 0, segment g is bit 6.
  localparam logic [6:0] SEG_CODE [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                           7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GATE_BITS-1:0]   gate_cnt_t;

  typedef enum int unsigned {WAVE_SQUARE, WAVE_NEAR, WAVE_NOISE} wave_e;

  typedef struct packed {
    logic [9:0] freq;
    logic       over;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [6:0] seg_hund;
    logic [6:0] seg_tens;
    logic [6:0] seg_ones;
  } gate_reading_t;

  class freq_scoreboard;
    sample_t       thresh;
    gate_cnt_t     gate_len;
    bit            level_high;
    logic [GATE_BITS:0] crossings;
    gate_cnt_t     taken;
    gate_reading_t expected_readings[$];
    int unsigned   failures;
    int unsigned   gates_checked;
    int unsigned   saturated_gates;

    function new();
      thresh          = sample_t'(RESET_THRESHOLD);
      gate_len        = gate_cnt_t'(gfc7_pkg::GATE_RESET);
      level_high      = 1'b0;
      crossings       = '0;
      taken           = '0;
      failures        = 0;
      gates_checked   = 0;
      saturated_gates = 0;
    endfunction

    function void write_register(gfc7_pkg::cfg_idx_t idx,
                                 logic [gfc7_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        gfc7_pkg::CFG_THRESHOLD:    thresh = data[SAMPLE_BITS-1:0];
        gfc7_pkg::CFG_GATE_SAMPLES: gate_len = data[GATE_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Updates the level flag and counts; queues a reading when the gate closes.
    function void note_sample(sample_t s);
      gate_cnt_t     limit;
      int unsigned   freq;
      gate_reading_t r;
      limit = (gate_len == '0) ? gate_cnt_t'(1) : gate_len;
      if (!level_high && s >= thresh) begin
        crossings  = crossings + (GATE_BITS + 1)'(1);
        level_high = 1'b1;
      end else if (level_high && s <= thresh) begin
        crossings  = crossings + (GATE_BITS + 1)'(1);
        level_high = 1'b0;
      end
      taken = taken + gate_cnt_t'(1);
      if (taken != '0 && taken < limit) return;
      freq   = int'(crossings >> 1);
      r.over = (freq > gfc7_pkg::FREQ_MAX);
      if (r.over) freq = 32'(gfc7_pkg::FREQ_MAX);
      r.freq     = 10'(freq);
      r.hund     = 4'(freq / 100);
      r.tens     = 4'((freq % 100) / 10);
      r.ones     = 4'(freq % 10);
      r.seg_hund = SEG_CODE[r.hund];
      r.seg_tens = SEG_CODE[r.tens];
      r.seg_ones = SEG_CODE[r.ones];
      expected_readings.push_back(r);
      crossings = '0;
      taken     = '0;
    endfunction

    task report(string msg);
      $display("MISMATCH %s", msg);
      failures++;
    endtask

    task compare_field(string name, logic [9:0] got, logic [9:0] want);
      if (got !== want)
        report($sformatf("gate %0d %s: got %0d, expected %0d", gates_checked, name, got, want));
    endtask

    task check_reading(gate_reading_t got);
      gate_reading_t want;
      if (expected_readings.size() == 0) begin
        report($sformatf("reading freq=%0d arrived with none expected", got.freq));
        return;
      end
      want = expected_readings.pop_front();
      gates_checked++;
      if (want.over) saturated_gates++;
      compare_field("frequency", got.freq, want.freq);
      compare_field("overrange", 10'(got.over), 10'(want.over));
      compare_field("digit_hundreds", 10'(got.hund), 10'(want.hund));
      compare_field("digit_tens", 10'(got.tens), 10'(want.tens));
      compare_field("digit_ones", 10'(got.ones), 10'(want.ones));
      compare_field("seg_hundreds", 10'(got.seg_hund), 10'(want.seg_hund));
      compare_field("seg_tens", 10'(got.seg_tens), 10'(want.seg_tens));
      compare_field("seg_ones", 10'(got.seg_ones), 10'(want.seg_ones));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rx_hold;

  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned cycle_count  = 0;
  int unsigned samples_sent = 0;

  freq_scoreboard sb;

  gfc7_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  gfc7_result_if reading_ch ();
  gfc7_cfg_if    cfg_ch ();

  gated_frequency_counter_7seg #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .GATE_BITS  (GATE_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_ch),
    .result_o(reading_ch),
    .cfg_i   (cfg_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One process sees every transfer of the edge, so the order of the
  // register write, the reading check and the sample update is fixed.
  always @(posedge clk_i) begin : monitor
    gate_reading_t got;
    if (rst_ni === 1'b1) begin
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
        sb.write_register(cfg_ch.index, cfg_ch.data);
      if (reading_ch.valid === 1'b1 && reading_ch.ready === 1'b1) begin
        got.freq     = reading_ch.frequency;
        got.over     = reading_ch.overrange;
        got.hund     = reading_ch.digit_hundreds;
        got.tens     = reading_ch.digit_tens;
        got.ones     = reading_ch.digit_ones;
        got.seg_hund = reading_ch.seg_hundreds;
        got.seg_tens = reading_ch.seg_tens;
        got.seg_ones = reading_ch.seg_ones;
        sb.check_reading(got);
      end
      if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
        sb.note_sample(sample_ch.sample);
    end
  end

  initial begin
    reading_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      reading_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  task offer_sample(sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk_i); while (sample_ch.ready !== 1'b1);
    samples_sent++;
  endtask

  // Stop sending and let every pending reading and any sample still in the
  // pipeline drain before the registers change.
  task pause_sender();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task write_reg(gfc7_pkg::cfg_idx_t idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
  endtask

  task configure(logic [31:0] thr_word, logic [31:0] gate_word, bit spare);
    pause_sender();
    write_reg(gfc7_pkg::CFG_THRESHOLD, thr_word);
    write_reg(gfc7_pkg::CFG_GATE_SAMPLES, gate_word);
    if (spare)
      write_reg(($urandom_range(1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
    cfg_ch.valid <= 1'b0;
  endtask

  task hold_receiver(int unsigned cycles);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
  endtask

  // Every sample crosses the threshold, so a gate of n samples counts n crossings.
  task send_alternating(int unsigned n);
    bit up;
    up = !sb.level_high;
    repeat (n) begin
      offer_sample(up ? sample_t'(SAMPLE_MAX) : sample_t'(0));
      up = !up;
    end
  endtask

  task send_wave(wave_e mode, int unsigned thr, int unsigned n);
    int unsigned half_period;
    int unsigned lo;
    int unsigned hi;
    sample_t     s;
    half_period = $urandom_range(8, 1);
    lo = (thr < 3) ? 0 : thr - 3;
    hi = (thr + 3 > SAMPLE_MAX) ? SAMPLE_MAX : thr + 3;
    for (int unsigned k = 0; k < n; k++) begin
      case (mode)
        WAVE_SQUARE: begin
          if ($urandom_range(9) == 0)
            s = sample_t'($urandom_range(SAMPLE_MAX, 0));
          else if ((k / half_period) % 2 == 1)
            s = sample_t'($urandom_range(SAMPLE_MAX, thr));
          else
            s = sample_t'($urandom_range(thr, 0));
        end
        WAVE_NEAR: s = sample_t'($urandom_range(hi, lo));
        default:   s = sample_t'($urandom_range(SAMPLE_MAX, 0));
      endcase
      offer_sample(s);
    end
  endtask

  initial begin
    int unsigned idle_mix [PHASES];
    int unsigned stall_mix [PHASES];
    int unsigned thr_val;
    int unsigned gate_val;
    int unsigned pick;
    wave_e       mode;

    idle_mix  = '{0, 54, 0, 7};
    stall_mix = '{0, 0, 54, 7};
    sb = new();

    rst_ni           <= 1'b0;
    rx_hold          <= 1'b0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= gfc7_pkg::CFG_THRESHOLD;
    cfg_ch.data      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, both sides of the threshold and exactly on it; the long
    // reset gate is then cut short below the samples already taken.
    offer_sample(0); offer_sample(1351); offer_sample(1352);
    offer_sample(1353); offer_sample(1352); offer_sample(4095);
    configure(RESET_THRESHOLD, 3, 1'b0);
    offer_sample(0);

    // Upper data bits are dropped; a zero gate length closes a gate per sample.
    configure(32'hABCD_E800, 32'h5A00_0000, 1'b1);
    offer_sample(4095); offer_sample(0); offer_sample(2048);
    offer_sample(2047); offer_sample(2048);

    configure(0, 1, 1'b1);
    offer_sample(0); offer_sample(0); offer_sample(4095); offer_sample(0);

    configure(SAMPLE_MAX, 1, 1'b0);
    offer_sample(4095); offer_sample(4094); offer_sample(4095); offer_sample(0);

    // Longest gate, then shortened mid-gate.
    configure(32'hFFFF_FFFF, GATE_MAX, 1'b0);
    offer_sample(0); offer_sample(4095); offer_sample(4095);
    configure(32'hFFFF_FFFF, 32'hFF00_0002, 1'b0);
    offer_sample(4095); offer_sample(0); offer_sample(4095);

    // One gate just above the display limit saturates the reading at 999.
    configure(MID_THRESHOLD, 2000, 1'b0);
    send_alternating(2000);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      pause_sender();
      idle_pct  = idle_mix[phase];
      stall_pct = stall_mix[phase];
      for (int unsigned seg = 0; seg < PHASE_SEGMENTS; seg++) begin
        pick = $urandom_range(9);
        thr_val = (pick == 0) ? 0 : (pick == 1) ? SAMPLE_MAX : $urandom_range(SAMPLE_MAX, 0);
        pick = $urandom_range(19);
        if (pick == 0)      gate_val = 0;
        else if (pick == 1) gate_val = GATE_MAX;
        else if (pick == 2) gate_val = $urandom_range(200, 60);
        else                gate_val = $urandom_range(24, 1);
        if (phase == 0 && seg == 0) gate_val = 1;
        configure(($urandom() & ~32'(SAMPLE_MAX)) | 32'(thr_val),
                  ($urandom() & ~32'(GATE_MAX)) | 32'(gate_val),
                  $urandom_range(3) == 0);
        // With one reading per sample and the receiver held off, the block
        // fills up and has to stall its sample input.
        if (phase == 0 && seg == 0) hold_receiver(HOLD_CYCLES);
        pick = $urandom_range(9);
        mode = (pick < 6) ? WAVE_SQUARE : (pick < 8) ? WAVE_NEAR : WAVE_NOISE;
        send_wave(mode, thr_val, SEGMENT_SAMPLES);
      end
    end

    pause_sender();
    $display("tb: %0d samples sent, %0d gate readings checked, %0d saturated",
             samples_sent, sb.gates_checked, sb.saturated_gates);
    $display("tb: covered register corners, gate cuts, the 999 limit and four idle/stall mixes");
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
